/* rtl/core/ksa_pkg.sv */
package ksa_pkg;

  localparam int VAL_W   = 31;
  localparam int MAG_W   = 8;
  localparam int MUL_B_W = 14;
  localparam int SUM_W   = VAL_W + 2;

  localparam logic [VAL_W-1:0] VAL_MAX       = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0] INIT_VELOCITY = VAL_W'(50000);
  localparam logic [VAL_W-1:0] INIT_ACCEL    = VAL_W'(10000);
  localparam logic [VAL_W-1:0] RST_STROKE    = VAL_W'(3600000);
  localparam logic [VAL_W-1:0] RST_VEL_LIM   = VAL_W'(1750000);
  localparam logic [VAL_W-1:0] RST_ACC_LIM   = VAL_W'(999000);

  localparam logic [MUL_B_W-1:0] POS_STEP = MUL_B_W'(10000);
  localparam logic [MUL_B_W-1:0] ACC_STEP = MUL_B_W'(1000);

  localparam logic OP_ROTATE = 1'b0;
  localparam logic OP_CLICK  = 1'b1;

  localparam logic [1:0] KNOB_START = 2'd0;
  localparam logic [1:0] KNOB_END   = 2'd1;
  localparam logic [1:0] KNOB_VEL   = 2'd2;
  localparam logic [1:0] KNOB_ACC   = 2'd3;

  localparam logic [1:0] CFG_STROKE_LIMIT = 2'd0;
  localparam logic [1:0] CFG_VEL_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_ACC_LIMIT    = 2'd2;
  localparam logic [1:0] CFG_LIMITS_VALID = 2'd3;

  localparam logic [3:0] MASK_NONE  = 4'b0000;
  localparam logic [3:0] MASK_START = 4'b0001;
  localparam logic [3:0] MASK_END   = 4'b0010;
  localparam logic [3:0] MASK_VEL   = 4'b0100;
  localparam logic [3:0] MASK_ACC   = 4'b1000;
  localparam logic [3:0] MASK_ALL   = 4'b1111;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_CUBE,
    ST_SCALE,
    ST_ADD,
    ST_COMMIT
  } state_t;

  typedef enum logic [1:0] {
    SEL_MAG,
    SEL_POS_STEP,
    SEL_ACC_STEP
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     add_en;
    logic     commit;
  } ctrl_t;

endpackage

/* rtl/core/ksa_mul.sv */
module ksa_mul
  import ksa_pkg::*;
(
  input  logic             clk,
  input  logic             load,
  input  logic [MAG_W-1:0] mag,
  input  logic             en,
  input  mul_sel_t         sel,
  output logic [VAL_W-1:0] prod
);

  logic [VAL_W-1:0]         prod_r;
  logic [MUL_B_W-1:0]       b;
  logic [VAL_W+MUL_B_W-1:0] full;

  always_comb begin
    case (sel)
      SEL_POS_STEP: b = POS_STEP;
      SEL_ACC_STEP: b = ACC_STEP;
      default:      b = MUL_B_W'(mag);
    endcase
  end

  assign full = (VAL_W+MUL_B_W)'(prod_r) * (VAL_W+MUL_B_W)'(b);

  // largest true product is 128^3*1000, below 2^31
  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= VAL_W'(mag);
    end else if (en) begin
      prod_r <= full[VAL_W-1:0];
    end
  end

  assign prod = prod_r;

endmodule

/* rtl/core/ksa_ctrl.sv */
module ksa_ctrl
  import ksa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_op,
  input  logic [1:0] knob_r,
  input  logic       out_free,
  output logic       in_tready,
  output ctrl_t      ctrl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_op == OP_CLICK) ? ST_COMMIT : ST_SQ;
        end
      end
      ST_SQ:     state_nxt = (knob_r == KNOB_ACC) ? ST_CUBE : ST_SCALE;
      ST_CUBE:   state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_ADD;
      ST_ADD:    state_nxt = ST_COMMIT;
      ST_COMMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    ctrl         = '0;
    ctrl.mul_sel = SEL_MAG;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        ctrl.load = in_tvalid;
      end
      ST_SQ, ST_CUBE: ctrl.mul_en = 1'b1;
      ST_SCALE: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = (knob_r == KNOB_ACC) ? SEL_ACC_STEP : SEL_POS_STEP;
      end
      ST_ADD:    ctrl.add_en = 1'b1;
      ST_COMMIT: ctrl.commit = out_free;
      default: ;
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in progress");

  a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.commit |-> out_free)
    else $error("result overwrote a pending transfer");

  a_cube_only_accel: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CUBE |-> knob_r == KNOB_ACC)
    else $error("cubic step on a non-acceleration knob");

endmodule

/* rtl/core/knob_setpoint_adjuster.sv */
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_tvalid/in_tready  | tuser: operation, knob; tdata: rotation_diff
// out_    | output    | out_tvalid/out_tready| tdata: setpoints, flags, changed_mask
// cfg_    | input     | cfg_wen              | cfg_addr index, cfg_wdata value
//
// A rotation steps through square, scale, add and commit (the acceleration knob adds a
// cubing step after the square); a click goes from idle straight to commit, and every item
// returns to idle afterwards. The shared multiplier does one step per cycle.
// in_tready is high only while the sequencer is idle; one item is in work at a time.
// A finished result waits in the output register; the next item is taken meanwhile
// and holds in its final step until that register is free.
// rst_n is synchronous and restores setpoints, flags and limits to their initial values.
module knob_setpoint_adjuster
  import ksa_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] rotation_diff
  input  logic [2:0]   in_tuser,   // [0] operation, [2:1] knob
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // [30:0] start_pos, [61:31] end_pos,
                                   // [92:62] velocity, [123:93] acceleration,
                                   // [124] enabled, [125] stopped,
                                   // [129:126] changed_mask, [135:130] zero
  input  logic         cfg_wen,
  input  logic [1:0]   cfg_addr,
  input  logic [30:0]  cfg_wdata
);

  ctrl_t ctrl;
  logic  out_free;

  logic [VAL_W-1:0] stroke_lim_r, vel_lim_r, acc_lim_r;
  logic             limits_valid_r;

  logic             op_r;
  logic [1:0]       knob_r;
  logic             neg_r;
  logic [MAG_W-1:0] mag;
  logic [VAL_W-1:0] prod;

  // multiplier operand for squaring/cubing is kept in a register of its own
  logic [MAG_W-1:0] mag_r;

  logic [VAL_W-1:0] start_pos_r, end_pos_r, vel_r, acc_r;
  logic [VAL_W-1:0] start_nxt, end_nxt, vel_nxt, acc_nxt;
  logic             enable_r, stop_r, enable_nxt, stop_nxt;
  logic [3:0]       mask_nxt;

  logic [VAL_W-1:0] base, bound, sat_r, lim_val;
  logic [SUM_W-1:0] sum;

  logic             out_tvalid_r;
  logic [VAL_W-1:0] o_start_r, o_end_r, o_vel_r, o_acc_r;
  logic             o_en_r, o_stop_r;
  logic [3:0]       o_mask_r;

  assign out_free = !out_tvalid_r || out_tready;

  ksa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser[0]),
    .knob_r    (knob_r),
    .out_free  (out_free),
    .in_tready (in_tready),
    .ctrl      (ctrl)
  );

  assign mag = in_tdata[7] ? MAG_W'(-in_tdata) : in_tdata;

  ksa_mul u_mul (
    .clk  (clk),
    .load (ctrl.load),
    .mag  (ctrl.load ? mag : mag_r),
    .en   (ctrl.mul_en),
    .sel  (ctrl.mul_sel),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stroke_lim_r   <= RST_STROKE;
      vel_lim_r      <= RST_VEL_LIM;
      acc_lim_r      <= RST_ACC_LIM;
      limits_valid_r <= 1'b0;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        CFG_STROKE_LIMIT: stroke_lim_r   <= cfg_wdata;
        CFG_VEL_LIMIT:    vel_lim_r      <= cfg_wdata;
        CFG_ACC_LIMIT:    acc_lim_r      <= cfg_wdata;
        CFG_LIMITS_VALID: limits_valid_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_r   <= in_tuser[0];
      knob_r <= in_tuser[2:1];
      neg_r  <= in_tdata[7];
      mag_r  <= mag;
    end
  end

  always_comb begin
    case (knob_r)
      KNOB_START: base = start_pos_r;
      KNOB_END:   base = end_pos_r;
      KNOB_VEL:   base = vel_r;
      default:    base = acc_r;
    endcase
  end

  assign sum = SUM_W'(base) + (neg_r ? -SUM_W'(prod) : SUM_W'(prod));

  always_ff @(posedge clk) begin
    if (ctrl.add_en) begin
      if (sum[SUM_W-1]) begin
        sat_r <= '0;
      end else if (sum[SUM_W-2]) begin
        sat_r <= VAL_MAX;
      end else begin
        sat_r <= sum[VAL_W-1:0];
      end
    end
  end

  always_comb begin
    case (knob_r)
      KNOB_VEL: bound = vel_lim_r;
      KNOB_ACC: bound = acc_lim_r;
      default:  bound = stroke_lim_r;
    endcase
  end

  assign lim_val = (limits_valid_r && (sat_r > bound)) ? bound : sat_r;

  always_comb begin
    start_nxt  = start_pos_r;
    end_nxt    = end_pos_r;
    vel_nxt    = vel_r;
    acc_nxt    = acc_r;
    enable_nxt = enable_r;
    stop_nxt   = stop_r;
    mask_nxt   = MASK_NONE;
    if (op_r == OP_ROTATE) begin
      case (knob_r)
        KNOB_START: begin
          start_nxt = lim_val;
          mask_nxt  = MASK_START;
          if (lim_val > end_pos_r) begin
            end_nxt  = lim_val;
            mask_nxt = MASK_START | MASK_END;
          end
        end
        KNOB_END: begin
          end_nxt  = lim_val;
          mask_nxt = MASK_END;
          // pull-down compares before the stroke limit is applied
          if (sat_r < start_pos_r) begin
            start_nxt = sat_r;
            mask_nxt  = MASK_START | MASK_END;
          end
        end
        KNOB_VEL: begin
          vel_nxt  = lim_val;
          mask_nxt = MASK_VEL;
        end
        default: begin
          acc_nxt  = lim_val;
          mask_nxt = MASK_ACC;
        end
      endcase
    end else begin
      case (knob_r)
        KNOB_START: enable_nxt = !enable_r;
        KNOB_END:   stop_nxt   = !stop_r;
        KNOB_VEL:   ;
        default: begin
          start_nxt = '0;
          end_nxt   = '0;
          vel_nxt   = INIT_VELOCITY;
          acc_nxt   = INIT_ACCEL;
          stop_nxt  = 1'b0;
          mask_nxt  = MASK_ALL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pos_r <= '0;
      end_pos_r   <= '0;
      vel_r       <= INIT_VELOCITY;
      acc_r       <= INIT_ACCEL;
      enable_r    <= 1'b0;
      stop_r      <= 1'b0;
    end else if (ctrl.commit) begin
      start_pos_r <= start_nxt;
      end_pos_r   <= end_nxt;
      vel_r       <= vel_nxt;
      acc_r       <= acc_nxt;
      enable_r    <= enable_nxt;
      stop_r      <= stop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctrl.commit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      o_start_r <= start_nxt;
      o_end_r   <= end_nxt;
      o_vel_r   <= vel_nxt;
      o_acc_r   <= acc_nxt;
      o_en_r    <= enable_nxt;
      o_stop_r  <= stop_nxt;
      o_mask_r  <= mask_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'b0, o_mask_r, o_stop_r, o_en_r, o_acc_r, o_vel_r, o_end_r, o_start_r};

  a_commit_presents: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.commit |=> out_tvalid)
    else $error("committed result not presented");

  a_idle_no_result_change: assert property (@(posedge clk) disable iff (!rst_n)
    !ctrl.commit |=> $stable(start_pos_r) && $stable(end_pos_r) && $stable(vel_r)
                     && $stable(acc_r))
    else $error("setpoint changed outside commit");

  a_mag_held: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.mul_en |=> $stable(mag_r))
    else $error("operand changed during multiply sequence");

endmodule
